// ----- sv/fdcc_pkg.sv -----
// ----------------------------------------------------------------------------
// fdcc_pkg: shared types and constants for the deadline capacity check
// Field widths, register indexes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fdcc_pkg;

  localparam int unsigned DAY_W   = 16;
  localparam int unsigned JOB_W   = 16;
  localparam int unsigned PEND_W  = 24;
  localparam int unsigned ENTRY_W = DAY_W + JOB_W;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 1;

  localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};
  localparam logic [DAY_W-1:0]  DAY_MAX  = {DAY_W{1'b1}};

  localparam logic [CIDX_W-1:0] CFG_SERVERS  = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_DEADLINE = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SERVE,
    ST_FETCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic serve_done;
    logic head_loaded;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/fdcc_ram.sv -----
// ----------------------------------------------------------------------------
// fdcc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fdcc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/fdcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fdcc_ctrl: sequencer for one day
// Accept a word, serve the queue head until budget or queue runs out,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module fdcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fdcc_pkg::dp_stat_t stat,
  output fdcc_pkg::dp_cmd_t  cmd
);

  fdcc_pkg::state_t state_r;
  fdcc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdcc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdcc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = fdcc_pkg::ST_SERVE;
        end
      end
      fdcc_pkg::ST_SERVE: begin
        if (stat.serve_done) begin
          state_nxt = fdcc_pkg::ST_FINISH;
        end else if (!stat.head_loaded) begin
          state_nxt = fdcc_pkg::ST_FETCH;
        end
      end
      fdcc_pkg::ST_FETCH: begin
        state_nxt = fdcc_pkg::ST_SERVE;
      end
      fdcc_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          state_nxt = fdcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fdcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      fdcc_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      fdcc_pkg::ST_SERVE: begin
        if (!stat.serve_done) begin
          // fetch the head entry first if it is not cached
          cmd.fetch = !stat.head_loaded;
          cmd.step  = stat.head_loaded;
        end
      end
      fdcc_pkg::ST_FETCH: begin
        cmd.load = 1'b1;
      end
      fdcc_pkg::ST_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- sv/fdcc_dp.sv -----
// ----------------------------------------------------------------------------
// fdcc_dp: queue, counters and result register
// Holds the day queue in RAM with a cached head entry, the horizon counters,
// the configuration registers and the output register.
// ----------------------------------------------------------------------------
module fdcc_dp #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fdcc_pkg::dp_cmd_t                cmd,
  output fdcc_pkg::dp_stat_t               stat,
  input  logic [fdcc_pkg::JOB_W-1:0]       in_new_jobs,
  input  logic                             in_final_day,
  input  logic                             cfg_valid,
  input  logic [fdcc_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [fdcc_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fdcc_pkg::JOB_W-1:0]       out_served_today,
  output logic [fdcc_pkg::PEND_W-1:0]      out_backlog,
  output logic [fdcc_pkg::DAY_W-1:0]       out_worst_delay,
  output logic                             out_feasible,
  output logic                             out_queue_overflow,
  output logic                             out_last_result
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  localparam int unsigned DW = fdcc_pkg::DAY_W;
  localparam int unsigned JW = fdcc_pkg::JOB_W;
  localparam int unsigned PW = fdcc_pkg::PEND_W;

  // configuration
  logic [JW-1:0] srv_cfg_r;
  logic [DW-1:0] dl_cfg_r;

  // horizon state
  logic [DW-1:0] day_r,    day_nxt;
  logic [AW-1:0] head_r,   head_nxt;
  logic [AW-1:0] tail_r,   tail_nxt;
  logic [CW-1:0] cnt_r,    cnt_nxt;
  logic [PW-1:0] pend_r,   pend_nxt;
  logic [DW-1:0] maxd_r,   maxd_nxt;
  logic          ovf_r,    ovf_nxt;
  logic          hl_r,     hl_nxt;
  logic [DW-1:0] hreq_r,   hreq_nxt;
  logic [JW-1:0] hcnt_r,   hcnt_nxt;

  // per-day state
  logic [JW-1:0] budget_r, budget_nxt;
  logic [JW-1:0] served_r, served_nxt;
  logic          last_r,   last_nxt;

  // output register
  logic          ov_r,     ov_nxt;
  logic [JW-1:0] o_srv_r,  o_srv_nxt;
  logic [PW-1:0] o_pend_r, o_pend_nxt;
  logic [DW-1:0] o_maxd_r, o_maxd_nxt;
  logic          o_feas_r, o_feas_nxt;
  logic          o_ovf_r,  o_ovf_nxt;
  logic          o_last_r, o_last_nxt;

  // RAM port
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [fdcc_pkg::ENTRY_W-1:0]    ram_wdata;
  logic                            ram_re;
  logic [fdcc_pkg::ENTRY_W-1:0]    ram_rdata;

  // helpers
  logic [DW-1:0] day_inc;
  logic [PW:0]   pend_sum;
  logic [JW-1:0] take;
  logic [DW-1:0] delay;
  logic [PW-1:0] pend_fin;

  fdcc_ram #(
    .WIDTH (fdcc_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign day_inc  = (day_r == fdcc_pkg::DAY_MAX) ? day_r : day_r + 1'b1;
  assign pend_sum = {1'b0, pend_r} + (PW + 1)'(in_new_jobs);
  assign take     = (hcnt_r < budget_r) ? hcnt_r : budget_r;
  assign delay    = day_r - hreq_r;
  assign pend_fin = (cnt_r == '0) ? '0 : pend_r;

  assign stat.serve_done  = (budget_r == '0) || (cnt_r == '0);
  assign stat.head_loaded = hl_r;
  assign stat.out_free    = !ov_r || out_ready;

  assign ram_re    = cmd.fetch;
  assign ram_waddr = tail_r;
  assign ram_wdata = {day_inc, in_new_jobs};
  assign ram_we    = cmd.accept && (in_new_jobs != '0) && (cnt_r != CNT_FULL);

  always_comb begin
    day_nxt    = day_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    maxd_nxt   = maxd_r;
    ovf_nxt    = ovf_r;
    hl_nxt     = hl_r;
    hreq_nxt   = hreq_r;
    hcnt_nxt   = hcnt_r;
    budget_nxt = budget_r;
    served_nxt = served_r;
    last_nxt   = last_r;
    ov_nxt     = ov_r && !out_ready;
    o_srv_nxt  = o_srv_r;
    o_pend_nxt = o_pend_r;
    o_maxd_nxt = o_maxd_r;
    o_feas_nxt = o_feas_r;
    o_ovf_nxt  = o_ovf_r;
    o_last_nxt = o_last_r;

    if (cmd.accept) begin
      day_nxt    = day_inc;
      budget_nxt = srv_cfg_r;
      served_nxt = '0;
      last_nxt   = in_final_day;
      if (in_new_jobs != '0) begin
        if (cnt_r == CNT_FULL) begin
          // no room: drop the day's entry
          ovf_nxt = 1'b1;
        end else begin
          tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if (pend_r != fdcc_pkg::PEND_MAX) begin
            pend_nxt = pend_sum[PW] ? fdcc_pkg::PEND_MAX : pend_sum[PW-1:0];
          end
        end
      end
    end

    if (cmd.load) begin
      hreq_nxt = ram_rdata[fdcc_pkg::ENTRY_W-1:JW];
      hcnt_nxt = ram_rdata[JW-1:0];
      hl_nxt   = 1'b1;
    end

    if (cmd.step) begin
      if (delay > maxd_r) begin
        maxd_nxt = delay;
      end
      budget_nxt = budget_r - take;
      served_nxt = served_r + take;
      hcnt_nxt   = hcnt_r - take;
      if (hcnt_r == take) begin
        // head entry drained: pop it
        head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        hl_nxt   = 1'b0;
      end
      if (pend_r != fdcc_pkg::PEND_MAX) begin
        pend_nxt = (pend_r > PW'(take)) ? pend_r - PW'(take) : '0;
      end
    end

    if (cmd.finish) begin
      ov_nxt     = 1'b1;
      o_srv_nxt  = served_r;
      o_pend_nxt = pend_fin;
      o_maxd_nxt = maxd_r;
      o_feas_nxt = (cnt_r == '0) && !ovf_r && (maxd_r <= dl_cfg_r);
      o_ovf_nxt  = ovf_r;
      o_last_nxt = last_r;
      pend_nxt   = pend_fin;
      if (last_r) begin
        // end of horizon: start over at day 1 on the next word
        day_nxt  = '0;
        head_nxt = '0;
        tail_nxt = '0;
        cnt_nxt  = '0;
        pend_nxt = '0;
        maxd_nxt = '0;
        ovf_nxt  = 1'b0;
        hl_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srv_cfg_r <= JW'(1);
      dl_cfg_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        fdcc_pkg::CFG_SERVERS:  srv_cfg_r <= cfg_wdata;
        fdcc_pkg::CFG_DEADLINE: dl_cfg_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r    <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
      pend_r   <= '0;
      maxd_r   <= '0;
      ovf_r    <= 1'b0;
      hl_r     <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      day_r    <= day_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      maxd_r   <= maxd_nxt;
      ovf_r    <= ovf_nxt;
      hl_r     <= hl_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hreq_r   <= hreq_nxt;
    hcnt_r   <= hcnt_nxt;
    budget_r <= budget_nxt;
    served_r <= served_nxt;
    last_r   <= last_nxt;
    o_srv_r  <= o_srv_nxt;
    o_pend_r <= o_pend_nxt;
    o_maxd_r <= o_maxd_nxt;
    o_feas_r <= o_feas_nxt;
    o_ovf_r  <= o_ovf_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid          = ov_r;
  assign out_served_today   = o_srv_r;
  assign out_backlog        = o_pend_r;
  assign out_worst_delay    = o_maxd_r;
  assign out_feasible       = o_feas_r;
  assign out_queue_overflow = o_ovf_r;
  assign out_last_result    = o_last_r;

endmodule

// ----- sv/fifo_deadline_capacity_check.sv -----
// ----------------------------------------------------------------------------
// fifo_deadline_capacity_check: multi-server FIFO deadline check
// One input word per day carries the day's new job count; one result word
// per day reports jobs served, backlog, worst delay and feasibility.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per day (new_jobs, final_day), valid/ready.
//   out_* : one result word per input word, in order, valid/ready.
//   cfg_* : register writes (index 0 servers per day, 1 deadline in days);
//           always ready, write only while the block is idle.
// Sequence: accept, serve check, result load; each entry fetched from the RAM
// adds a read, a load and a serve step, and a head entry cached from an earlier
// day adds a serve step. A new word is taken only after the last result loads;
// the single RAM read port at the queue head sets the cost per entry.
// Receiver stall: the next word is accepted and served while the result
// waits, then holds until the output register frees up.
// Reset: queue empty, counters and overflow flag cleared, servers_per_day = 1,
// deadline_days = 0, no clearing pass; a last_result word also clears it.
// ----------------------------------------------------------------------------
module fifo_deadline_capacity_check #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fdcc_pkg::JOB_W-1:0]       in_new_jobs,
  input  logic                             in_final_day,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fdcc_pkg::JOB_W-1:0]       out_served_today,
  output logic [fdcc_pkg::PEND_W-1:0]      out_backlog,
  output logic [fdcc_pkg::DAY_W-1:0]       out_worst_delay,
  output logic                             out_feasible,
  output logic                             out_queue_overflow,
  output logic                             out_last_result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fdcc_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [fdcc_pkg::CFG_W-1:0]       cfg_wdata
);

  fdcc_pkg::dp_cmd_t  cmd;
  fdcc_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  fdcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fdcc_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_new_jobs        (in_new_jobs),
    .in_final_day       (in_final_day),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_served_today   (out_served_today),
    .out_backlog        (out_backlog),
    .out_worst_delay    (out_worst_delay),
    .out_feasible       (out_feasible),
    .out_queue_overflow (out_queue_overflow),
    .out_last_result    (out_last_result)
  );

endmodule
